### src/tlseq_pkg.sv
// shared types, constants and lamp tables of the traffic light sequencer
package tlseq_pkg;

    localparam int PHASES   = 12;
    localparam int PHASE_W  = 4;
    localparam int TICK_W   = 12;
    localparam int ALERT_W  = 16;
    localparam int PORTC_W  = 8;
    localparam int PORTD_W  = 4;
    localparam int BTN_W    = 4;
    localparam int TABLE_N  = 16;
    localparam int ALARM_N  = 4;

    localparam logic [ALERT_W-1:0] ALERT_DURATION_RESET = 16'd400;

    typedef logic [PHASE_W-1:0] phase_t;

    typedef enum logic {
        FUNC_TICK   = 1'b0,
        FUNC_BUTTON = 1'b1
    } func_t;

    typedef struct packed {
        func_t            func;
        logic [BTN_W-1:0] buttons;
    } item_t;

    typedef struct packed {
        phase_t             phase;
        logic [TICK_W-1:0]  tick;
        logic [ALERT_W-1:0] alert_cnt;
        logic [PORTC_W-1:0] pat_c;
        logic [PORTD_W-1:0] pat_d;
    } seq_state_t;

    localparam logic [TICK_W-1:0] END_TIME [TABLE_N] = '{
        12'd500,  12'd700,  12'd1000, 12'd1500, 12'd1700, 12'd2000, 12'd2500, 12'd2700,
        12'd3000, 12'd3500, 12'd3700, 12'd4000, 12'd4020, 12'd4040, 12'd4060, 12'd4080
    };

    localparam logic [PORTC_W-1:0] SEQ_C [TABLE_N] = '{
        8'h24, 8'h24, 8'h24, 8'h64, 8'hA4, 8'h24, 8'h0C, 8'h14,
        8'h24, 8'h21, 8'h22, 8'h24, 8'h24, 8'h24, 8'h24, 8'h24
    };

    localparam logic [PORTD_W-1:0] SEQ_D [TABLE_N] = '{
        4'h3, 4'h5, 4'h9, 4'h8, 4'h8, 4'h9, 4'h9, 4'h9,
        4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9
    };

    localparam logic [PORTC_W-1:0] ALARM_C [ALARM_N] = '{8'h21, 8'h0C, 8'h64, 8'h24};
    localparam logic [PORTD_W-1:0] ALARM_D [ALARM_N] = '{4'h9, 4'h9, 4'h8, 4'h3};

    localparam phase_t RESET_PHASE = 4'd1;

    localparam seq_state_t STATE_RESET = '{
        phase:     RESET_PHASE,
        tick:      '0,
        alert_cnt: '0,
        pat_c:     SEQ_C[RESET_PHASE],
        pat_d:     SEQ_D[RESET_PHASE]
    };

endpackage

### src/tlseq_step.sv
// next-state logic for one tick or button transfer
module tlseq_step (
    input  tlseq_pkg::seq_state_t               state,
    input  tlseq_pkg::item_t                    item,
    input  logic [tlseq_pkg::ALERT_W-1:0]       alert_duration,
    output tlseq_pkg::seq_state_t               state_next
);
    import tlseq_pkg::*;

    logic [TICK_W-1:0]  tick_inc;
    logic [ALERT_W:0]   alert_inc;
    logic [PHASE_W:0]   phase_inc;
    phase_t             phase_new;
    logic [1:0]         btn_sel;

    assign tick_inc  = state.tick + TICK_W'(1);
    assign alert_inc = {1'b0, state.alert_cnt} + (ALERT_W+1)'(1);
    assign phase_inc = {1'b0, state.phase} + (PHASE_W+1)'(1);
    assign phase_new = (phase_inc >= (PHASE_W+1)'(PHASES)) ? '0 : phase_inc[PHASE_W-1:0];

    // button 0 wins
    always_comb begin
        priority if (item.buttons[0]) btn_sel = 2'd0;
        else if (item.buttons[1])     btn_sel = 2'd1;
        else if (item.buttons[2])     btn_sel = 2'd2;
        else                          btn_sel = 2'd3;
    end

    always_comb begin
        state_next = state;
        unique case (item.func)
            FUNC_TICK: begin
                if (state.alert_cnt == '0) begin
                    state_next.tick = tick_inc;
                    if (tick_inc == END_TIME[state.phase]) begin
                        state_next.phase = phase_new;
                        state_next.pat_c = SEQ_C[phase_new];
                        state_next.pat_d = SEQ_D[phase_new];
                        if (phase_new == '0) begin
                            state_next.tick = '0;
                        end
                    end
                end else if (alert_inc >= {1'b0, alert_duration}) begin
                    state_next.alert_cnt = '0;
                    state_next.pat_c     = SEQ_C[state.phase];
                    state_next.pat_d     = SEQ_D[state.phase];
                end else begin
                    state_next.alert_cnt = alert_inc[ALERT_W-1:0];
                end
            end
            FUNC_BUTTON: begin
                if (item.buttons != '0) begin
                    state_next.alert_cnt = ALERT_W'(1);
                    state_next.pat_c     = ALARM_C[btn_sel];
                    state_next.pat_d     = ALARM_D[btn_sel];
                end
            end
            default: state_next = state;
        endcase
    end

endmodule

### src/traffic_light_sequencer.sv
// traffic light sequencer top level: input register, state update, result register
//
//  channel   dir  handshake          tdata                                    tuser
//  s_        in   s_tvalid/s_tready  [3:0] buttons                            [0] func
//  m_        out  m_tvalid/m_tready  [7:0] port_c [11:8] port_d [15:12] phase [0] alert_active
//  cfg_      in   cfg_wen            [15:0] alert_duration                    -
//
//  one transfer per cycle in each direction while m_ is not stalled; an s_ item passes
//  through the input register, then the state and result registers, on its way to m_
//  reset gives phase 1, counts zero and alert_duration 400
//  a stall on m_ holds the result and the input register, then s_tready drops
module traffic_light_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] buttons
    input  logic [0:0]  s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] port_c, [11:8] port_d, [15:12] phase
    output logic [0:0]  m_tuser,   // [0] alert_active
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata
);
    import tlseq_pkg::*;

    logic                 in_valid_reg;
    item_t                item_reg;
    logic                 out_valid_reg;
    logic [15:0]          out_data_reg;
    logic                 out_alert_reg;
    seq_state_t           state_reg;
    seq_state_t           state_next;
    logic [ALERT_W-1:0]   duration_reg;
    logic                 advance;
    logic                 in_xfer;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    tlseq_step u_step (
        .state          (state_reg),
        .item           (item_reg),
        .alert_duration (duration_reg),
        .state_next     (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
            duration_reg  <= ALERT_DURATION_RESET;
        end else begin
            if (cfg_wen) begin
                duration_reg <= cfg_wdata;
            end
            if (in_xfer) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            item_reg <= '{func: func_t'(s_tuser[0]), buttons: s_tdata[BTN_W-1:0]};
        end
        if (advance) begin
            out_data_reg  <= {state_next.phase, state_next.pat_d, state_next.pat_c};
            out_alert_reg <= (state_next.alert_cnt != '0);
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_alert_reg;

endmodule

### src/tlseq_checker.sv
// port-level checks of the traffic light sequencer and their binding
module tlseq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [0:0]  m_tuser
);
    import tlseq_pkg::*;

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // input side only stalls behind a stalled output
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

    // phase number stays in range
    a_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:12] < PHASE_W'(PHASES))
        else $error("phase out of range");

    // without an alert the lamps show the phase pattern
    a_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            m_tdata[7:0] == SEQ_C[m_tdata[15:12]] && m_tdata[11:8] == SEQ_D[m_tdata[15:12]])
        else $error("lamp pattern does not match phase");

endmodule

bind traffic_light_sequencer tlseq_checker u_tlseq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
